/* rtl/bfm_pkg.sv */
// shared constants, types and the symbol decoder of the brainfuck machine
package bfm_pkg;

    localparam int PROG_DEPTH  = 4096;
    localparam int MEM_DEPTH   = 32768;
    localparam int STACK_DEPTH = 256;

    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int DA_W = $clog2(MEM_DEPTH);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SD_W = $clog2(STACK_DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int CELL_W = 8;
    localparam int STAT_W = 3;

    // commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNBAL = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEEP  = 3'd4;

    // program characters
    localparam logic [7:0] SYM_INC   = 8'h2B;
    localparam logic [7:0] SYM_DEC   = 8'h2D;
    localparam logic [7:0] SYM_RIGHT = 8'h3E;
    localparam logic [7:0] SYM_LEFT  = 8'h3C;
    localparam logic [7:0] SYM_OUT   = 8'h2E;
    localparam logic [7:0] SYM_IN    = 8'h2C;
    localparam logic [7:0] SYM_OPEN  = 8'h5B;
    localparam logic [7:0] SYM_CLOSE = 8'h5D;

    typedef enum logic [OP_W-1:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_dec;

    typedef struct packed {
        logic              clearing;
        logic [STAT_W-1:0] err;
    } t_bfm_stat;

    function automatic t_dec decode_symbol(input logic [7:0] s);
        t_dec d;
        d.valid = 1'b1;
        d.op    = OP_INC;
        case (s)
            SYM_INC:   d.op = OP_INC;
            SYM_DEC:   d.op = OP_DEC;
            SYM_RIGHT: d.op = OP_RIGHT;
            SYM_LEFT:  d.op = OP_LEFT;
            SYM_OUT:   d.op = OP_OUT;
            SYM_IN:    d.op = OP_IN;
            SYM_OPEN:  d.op = OP_OPEN;
            SYM_CLOSE: d.op = OP_CLOSE;
            default:   d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/bfm_ram.sv */
// generic simple dual-port ram with registered read
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfm_ctrl.sv */
// sequencer of the brainfuck machine: loading, bracket pairing, execution, result slot
module bfm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_symbol,
    input  logic                          i_in_valid,
    input  logic [7:0]                    i_in_byte,
    // result side
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_byte,
    output logic [bfm_pkg::STAT_W-1:0]    o_status,
    // program store
    output logic                          o_prog_we,
    output logic [bfm_pkg::PA_W-1:0]      o_prog_waddr,
    output logic [bfm_pkg::OP_W-1:0]      o_prog_wdata,
    output logic [bfm_pkg::PA_W-1:0]      o_prog_raddr,
    input  logic [bfm_pkg::OP_W-1:0]      i_prog_rdata,
    // match table
    output logic                          o_match_we,
    output logic [bfm_pkg::PA_W-1:0]      o_match_waddr,
    output logic [bfm_pkg::PA_W-1:0]      o_match_wdata,
    output logic [bfm_pkg::PA_W-1:0]      o_match_raddr,
    input  logic [bfm_pkg::PA_W-1:0]      i_match_rdata,
    // open-bracket stack
    output logic                          o_stack_we,
    output logic [bfm_pkg::SA_W-1:0]      o_stack_waddr,
    output logic [bfm_pkg::PA_W-1:0]      o_stack_wdata,
    output logic [bfm_pkg::SA_W-1:0]      o_stack_raddr,
    input  logic [bfm_pkg::PA_W-1:0]      i_stack_rdata,
    // data store
    output logic                          o_data_we,
    output logic [bfm_pkg::DA_W-1:0]      o_data_waddr,
    output logic [bfm_pkg::CELL_W-1:0]    o_data_wdata,
    output logic [bfm_pkg::DA_W-1:0]      o_data_raddr,
    input  logic [bfm_pkg::CELL_W-1:0]    i_data_rdata,
    // status
    output bfm_pkg::t_bfm_stat            o_stat
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_EXEC     = 6'b000100,
        S_CLOSE_RD = 6'b001000,
        S_CLOSE_WR = 6'b010000,
        S_RESULT   = 6'b100000
    } t_state;

    localparam int PA_W   = bfm_pkg::PA_W;
    localparam int PC_W   = bfm_pkg::PC_W;
    localparam int DA_W   = bfm_pkg::DA_W;
    localparam int SA_W   = bfm_pkg::SA_W;
    localparam int SD_W   = bfm_pkg::SD_W;
    localparam int STAT_W = bfm_pkg::STAT_W;
    localparam int CELL_W = bfm_pkg::CELL_W;

    t_state              r_state,   n_state;
    logic [DA_W-1:0]     r_clr,     n_clr;
    logic [SD_W-1:0]     r_depth,   n_depth;
    logic [PC_W-1:0]     r_lc,      n_lc;
    logic [PC_W-1:0]     r_rend,    n_rend;
    logic [PC_W-1:0]     r_pc,      n_pc;
    logic [DA_W-1:0]     r_dp,      n_dp;
    logic [STAT_W-1:0]   r_err,     n_err;
    logic                r_ovalid,  n_ovalid;
    // payload registers
    logic                r_in_valid, n_in_valid;
    logic [7:0]          r_in_byte,  n_in_byte;
    logic [PA_W-1:0]     r_partner,  n_partner;
    logic                r_oflag,    n_oflag;
    logic [7:0]          r_obyte,    n_obyte;
    logic [STAT_W-1:0]   r_ostat,    n_ostat;
    logic                r_pflag,    n_pflag;
    logic [7:0]          r_pbyte,    n_pbyte;
    logic [STAT_W-1:0]   r_pstat,    n_pstat;

    logic                accept;
    logic                out_free;
    logic                fin;
    logic                f_flag;
    logic [7:0]          f_byte;
    logic [STAT_W-1:0]   f_stat;
    logic [STAT_W-1:0]   f_final;
    bfm_pkg::t_dec       dec;
    bfm_pkg::t_op        prog_wop;
    bfm_pkg::t_op        exec_op;
    logic [CELL_W-1:0]   cur_cell;
    logic [PC_W-1:0]     jump;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign dec      = bfm_pkg::decode_symbol(i_symbol);
    assign exec_op  = bfm_pkg::t_op'(i_prog_rdata);
    assign cur_cell = i_data_rdata;
    assign jump     = PC_W'(i_match_rdata) + PC_W'(1);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_depth    = r_depth;
        n_lc       = r_lc;
        n_rend     = r_rend;
        n_pc       = r_pc;
        n_dp       = r_dp;
        n_err      = r_err;
        n_ovalid   = r_ovalid;
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        n_partner  = r_partner;
        n_oflag    = r_oflag;
        n_obyte    = r_obyte;
        n_ostat    = r_ostat;
        n_pflag    = r_pflag;
        n_pbyte    = r_pbyte;
        n_pstat    = r_pstat;

        o_prog_we     = 1'b0;
        o_prog_waddr  = r_lc[PA_W-1:0];
        prog_wop      = dec.op;
        o_prog_raddr  = r_pc[PA_W-1:0];
        o_match_we    = 1'b0;
        o_match_waddr = r_lc[PA_W-1:0];
        o_match_wdata = r_partner;
        o_match_raddr = r_pc[PA_W-1:0];
        o_stack_we    = 1'b0;
        o_stack_waddr = r_depth[SA_W-1:0];
        o_stack_wdata = r_lc[PA_W-1:0];
        o_stack_raddr = SA_W'(r_depth - SD_W'(1));
        o_data_we     = 1'b0;
        o_data_waddr  = r_dp;
        o_data_wdata  = '0;
        o_data_raddr  = r_dp;

        fin    = 1'b0;
        f_flag = 1'b0;
        f_byte = '0;
        f_stat = bfm_pkg::ST_OK;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_data_we    = 1'b1;
                o_data_waddr = r_clr;
                n_clr        = r_clr + DA_W'(1);
                if (r_clr == DA_W'(bfm_pkg::MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (r_err != bfm_pkg::ST_OK) begin
                        fin = 1'b1;
                    end else begin
                        case (i_command)
                            bfm_pkg::CMD_LOAD: begin
                                if (!dec.valid) begin
                                    fin = 1'b1;
                                end else if (r_lc == PC_W'(bfm_pkg::PROG_DEPTH)) begin
                                    n_err = bfm_pkg::ST_FULL;
                                    fin   = 1'b1;
                                end else if (dec.op == bfm_pkg::OP_OPEN) begin
                                    if (r_depth == SD_W'(bfm_pkg::STACK_DEPTH)) begin
                                        n_err = bfm_pkg::ST_DEEP;
                                    end else begin
                                        o_stack_we = 1'b1;
                                        o_prog_we  = 1'b1;
                                        n_depth    = r_depth + SD_W'(1);
                                        n_lc       = r_lc + PC_W'(1);
                                    end
                                    fin = 1'b1;
                                end else if (dec.op == bfm_pkg::OP_CLOSE) begin
                                    if (r_depth == '0) begin
                                        n_err = bfm_pkg::ST_UNBAL;
                                        fin   = 1'b1;
                                    end else begin
                                        // partner comes from the stack read issued now
                                        n_depth = r_depth - SD_W'(1);
                                        n_state = S_CLOSE_RD;
                                    end
                                end else begin
                                    o_prog_we = 1'b1;
                                    n_lc      = r_lc + PC_W'(1);
                                    if (r_depth == '0) begin
                                        n_rend = r_lc + PC_W'(1);
                                    end
                                    fin = 1'b1;
                                end
                            end
                            bfm_pkg::CMD_RUN: begin
                                if (r_pc >= r_rend) begin
                                    f_stat = bfm_pkg::ST_NONE;
                                    fin    = 1'b1;
                                end else begin
                                    // program, match and cell reads go out this cycle
                                    n_in_valid = i_in_valid;
                                    n_in_byte  = i_in_byte;
                                    n_state    = S_EXEC;
                                end
                            end
                            bfm_pkg::CMD_END: begin
                                if (r_depth != '0) begin
                                    n_err = bfm_pkg::ST_UNBAL;
                                end
                                fin = 1'b1;
                            end
                            default: begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_CLOSE_RD: begin
                n_partner     = i_stack_rdata;
                o_match_we    = 1'b1;
                o_match_waddr = i_stack_rdata;
                o_match_wdata = r_lc[PA_W-1:0];
                o_prog_we     = 1'b1;
                prog_wop      = bfm_pkg::OP_CLOSE;
                n_state       = S_CLOSE_WR;
            end
            S_CLOSE_WR: begin
                o_match_we = 1'b1;
                n_lc       = r_lc + PC_W'(1);
                if (r_depth == '0) begin
                    n_rend = r_lc + PC_W'(1);
                end
                fin = 1'b1;
            end
            S_EXEC: begin
                n_pc = r_pc + PC_W'(1);
                case (exec_op)
                    bfm_pkg::OP_INC: begin
                        o_data_we    = 1'b1;
                        o_data_wdata = cur_cell + CELL_W'(1);
                    end
                    bfm_pkg::OP_DEC: begin
                        o_data_we    = 1'b1;
                        o_data_wdata = cur_cell - CELL_W'(1);
                    end
                    bfm_pkg::OP_RIGHT: begin
                        n_dp = (r_dp == DA_W'(bfm_pkg::MEM_DEPTH - 1)) ? '0 : r_dp + DA_W'(1);
                    end
                    bfm_pkg::OP_LEFT: begin
                        n_dp = (r_dp == '0) ? DA_W'(bfm_pkg::MEM_DEPTH - 1) : r_dp - DA_W'(1);
                    end
                    bfm_pkg::OP_OUT: begin
                        f_flag = 1'b1;
                        f_byte = cur_cell;
                    end
                    bfm_pkg::OP_IN: begin
                        o_data_we    = r_in_valid;
                        o_data_wdata = r_in_byte;
                    end
                    bfm_pkg::OP_OPEN: begin
                        if (cur_cell == '0) begin
                            n_pc = jump;
                        end
                    end
                    default: begin
                        if (cur_cell != '0) begin
                            n_pc = jump;
                        end
                    end
                endcase
                fin = 1'b1;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oflag  = r_pflag;
                    n_obyte  = r_pbyte;
                    n_ostat  = r_pstat;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // an error reported by this transaction or earlier overrides the status
        f_final = (n_err != bfm_pkg::ST_OK) ? n_err : f_stat;
        if (fin) begin
            if (out_free) begin
                n_ovalid = 1'b1;
                n_oflag  = f_flag;
                n_obyte  = f_byte;
                n_ostat  = f_final;
                n_state  = S_IDLE;
            end else begin
                n_pflag  = f_flag;
                n_pbyte  = f_byte;
                n_pstat  = f_final;
                n_state  = S_RESULT;
            end
        end
    end

    assign o_prog_wdata = prog_wop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_depth  <= '0;
            r_lc     <= '0;
            r_rend   <= '0;
            r_pc     <= '0;
            r_dp     <= '0;
            r_err    <= bfm_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_depth  <= n_depth;
            r_lc     <= n_lc;
            r_rend   <= n_rend;
            r_pc     <= n_pc;
            r_dp     <= n_dp;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_valid <= n_in_valid;
        r_in_byte  <= n_in_byte;
        r_partner  <= n_partner;
        r_oflag    <= n_oflag;
        r_obyte    <= n_obyte;
        r_ostat    <= n_ostat;
        r_pflag    <= n_pflag;
        r_pbyte    <= n_pbyte;
        r_pstat    <= n_pstat;
    end

    assign o_valid     = r_ovalid;
    assign o_out_valid = r_oflag;
    assign o_out_byte  = r_obyte;
    assign o_status    = r_ostat;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.err      = r_err;

endmodule

/* rtl/brainfuck_machine_top.sv */
// top level of the brainfuck machine: stream ports, memories, sequencer
//
// One command transaction on the slave stream gives exactly one result transaction on the
// master stream. Command kinds: load a program character, run one instruction, end of
// program. Loading pairs brackets on the fly through an open-bracket stack; a run executes
// the instruction at the program counter when it lies in the balanced part of the program.
// Steps per transaction, accept to result register:
//   plain or '[' load, ignored character, end, run with nothing runnable: accept only
//   run of one instruction: program, match and cell reads, then execute and write back
//   load of ']': stack read, then the two match table writes
// The memory read latency and the write-back of the cell bound the run rate; the next run
// needs the pointer and cell left by the previous one.
// Results sit in an output register; a new command is taken while a result waits, and the
// block holds one more finished result internally before it deasserts tready.
// After reset a pass zeroes all MEM_DEPTH (32768) cells of the data store, during which
// tready stays low. Errors are sticky until reset and every later result reports them.
module brainfuck_machine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // symbol[7:0], in_byte[15:8]
    input  logic [2:0]  i_s_axis_tuser,  // command[1:0], in_valid[2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // out_byte[7:0], status[10:8], zero[15:11]
    output logic        o_m_axis_tuser   // out_valid[0]
);

    logic                              prog_we;
    logic [bfm_pkg::PA_W-1:0]          prog_waddr;
    logic [bfm_pkg::OP_W-1:0]          prog_wdata;
    logic [bfm_pkg::PA_W-1:0]          prog_raddr;
    logic [bfm_pkg::OP_W-1:0]          prog_rdata;
    logic                              match_we;
    logic [bfm_pkg::PA_W-1:0]          match_waddr;
    logic [bfm_pkg::PA_W-1:0]          match_wdata;
    logic [bfm_pkg::PA_W-1:0]          match_raddr;
    logic [bfm_pkg::PA_W-1:0]          match_rdata;
    logic                              stack_we;
    logic [bfm_pkg::SA_W-1:0]          stack_waddr;
    logic [bfm_pkg::PA_W-1:0]          stack_wdata;
    logic [bfm_pkg::SA_W-1:0]          stack_raddr;
    logic [bfm_pkg::PA_W-1:0]          stack_rdata;
    logic                              data_we;
    logic [bfm_pkg::DA_W-1:0]          data_waddr;
    logic [bfm_pkg::CELL_W-1:0]        data_wdata;
    logic [bfm_pkg::DA_W-1:0]          data_raddr;
    logic [bfm_pkg::CELL_W-1:0]        data_rdata;
    logic [7:0]                        out_byte;
    logic [bfm_pkg::STAT_W-1:0]        status;
    bfm_pkg::t_bfm_stat                stat;

    bfm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_command     (i_s_axis_tuser[1:0]),
        .i_symbol      (i_s_axis_tdata[7:0]),
        .i_in_valid    (i_s_axis_tuser[2]),
        .i_in_byte     (i_s_axis_tdata[15:8]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tuser),
        .o_out_byte    (out_byte),
        .o_status      (status),
        .o_prog_we     (prog_we),
        .o_prog_waddr  (prog_waddr),
        .o_prog_wdata  (prog_wdata),
        .o_prog_raddr  (prog_raddr),
        .i_prog_rdata  (prog_rdata),
        .o_match_we    (match_we),
        .o_match_waddr (match_waddr),
        .o_match_wdata (match_wdata),
        .o_match_raddr (match_raddr),
        .i_match_rdata (match_rdata),
        .o_stack_we    (stack_we),
        .o_stack_waddr (stack_waddr),
        .o_stack_wdata (stack_wdata),
        .o_stack_raddr (stack_raddr),
        .i_stack_rdata (stack_rdata),
        .o_data_we     (data_we),
        .o_data_waddr  (data_waddr),
        .o_data_wdata  (data_wdata),
        .o_data_raddr  (data_raddr),
        .i_data_rdata  (data_rdata),
        .o_stat        (stat)
    );

    bfm_ram #(.WIDTH(bfm_pkg::OP_W), .DEPTH(bfm_pkg::PROG_DEPTH)) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    bfm_ram #(.WIDTH(bfm_pkg::PA_W), .DEPTH(bfm_pkg::PROG_DEPTH)) u_match_ram (
        .i_clk   (i_clk),
        .i_we    (match_we),
        .i_waddr (match_waddr),
        .i_wdata (match_wdata),
        .i_raddr (match_raddr),
        .o_rdata (match_rdata)
    );

    bfm_ram #(.WIDTH(bfm_pkg::PA_W), .DEPTH(bfm_pkg::STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    bfm_ram #(.WIDTH(bfm_pkg::CELL_W), .DEPTH(bfm_pkg::MEM_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    assign o_m_axis_tdata = {5'b0, status, out_byte};

    // an error code never changes once set
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.err != bfm_pkg::ST_OK) |=> (stat.err == $past(stat.err)))
        else $error("error code changed after being set");

    // no command taken while the data store is being zeroed
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_s_axis_tready)
        else $error("command accepted during clearing pass");

    // an output byte only comes with an ok status
    a_out_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (status == bfm_pkg::ST_OK))
        else $error("output byte with non-ok status");

    // a result without output byte carries zero in that field
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (out_byte == '0))
        else $error("stray output byte");

endmodule

/* verif/testbench.sv */
// self-checking testbench of the brainfuck machine with its own interpreter model
module testbench;
    import bfm_pkg::*;

    localparam logic [1:0] CMD_SPARE      = 2'd3;
    localparam int         WORK_ITEMS     = 750;
    localparam int         WATCHDOG_LIMIT = 4 * MEM_DEPTH;
    localparam int         DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic              out_valid;
        logic [7:0]        out_byte;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] sym;
        logic       in_valid;
        logic [7:0] in_byte;
        logic       typed;
        result_t    want;
    } stim_row_t;

    typedef enum int {
        ERR_CLOSE,
        ERR_END,
        ERR_FULL,
        ERR_DEEP
    } error_case_t;

    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;    // symbol[7:0], in_byte[15:8]
    logic [2:0]  s_tuser  = '0;    // command[1:0], in_valid[2]
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;   // out_byte[7:0], status[10:8], zero[15:11]
    logic        o_m_axis_tuser;   // out_valid[0]

    // interpreter model state
    t_op               prog_ops   [PROG_DEPTH];
    logic [PA_W-1:0]   partner_of [PROG_DEPTH];
    logic [PA_W-1:0]   open_at    [STACK_DEPTH];
    logic [7:0]        cells      [MEM_DEPTH];
    int unsigned       depth_now    = 0;
    int unsigned       loaded       = 0;
    int unsigned       balanced_end = 0;
    int unsigned       pc_now       = 0;
    int unsigned       dptr         = 0;
    logic [STAT_W-1:0] sticky_err   = ST_OK;

    result_t    expected_results [$];
    logic [7:0] pending_syms [$];
    int         work_items   = 0;
    int         errors_seen  = 0;
    int         stall_cycles = 0;

    brainfuck_machine_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic decode_char(input logic [7:0] c, output t_op op);
        decode_char = 1'b1;
        op = OP_INC;
        case (c)
            SYM_INC:   op = OP_INC;
            SYM_DEC:   op = OP_DEC;
            SYM_RIGHT: op = OP_RIGHT;
            SYM_LEFT:  op = OP_LEFT;
            SYM_OUT:   op = OP_OUT;
            SYM_IN:    op = OP_IN;
            SYM_OPEN:  op = OP_OPEN;
            SYM_CLOSE: op = OP_CLOSE;
            default:   decode_char = 1'b0;
        endcase
    endfunction

    function automatic result_t step_machine(input logic [1:0] cmd, input logic [7:0] sym,
                                             input logic iv, input logic [7:0] ib);
        result_t         r;
        t_op             op;
        int unsigned     next_pc;
        logic [PA_W-1:0] mate;
        r = '0;
        if (sticky_err == ST_OK) begin
            case (cmd)
                CMD_LOAD: begin
                    if (decode_char(sym, op)) begin
                        // store full wins over the bracket checks
                        if (loaded >= PROG_DEPTH) begin
                            sticky_err = ST_FULL;
                        end else if (op == OP_OPEN && depth_now >= STACK_DEPTH) begin
                            sticky_err = ST_DEEP;
                        end else if (op == OP_CLOSE && depth_now == 0) begin
                            sticky_err = ST_UNBAL;
                        end else begin
                            if (op == OP_OPEN) begin
                                open_at[depth_now] = PA_W'(loaded);
                                depth_now++;
                            end else if (op == OP_CLOSE) begin
                                depth_now--;
                                mate = open_at[depth_now];
                                partner_of[mate] = PA_W'(loaded);
                                partner_of[loaded] = mate;
                            end
                            prog_ops[loaded] = op;
                            loaded++;
                            if (depth_now == 0) balanced_end = loaded;
                        end
                    end
                end
                CMD_RUN: begin
                    if (pc_now >= balanced_end) begin
                        r.status = ST_NONE;
                    end else begin
                        next_pc = pc_now + 1;
                        case (prog_ops[pc_now])
                            OP_INC:   cells[dptr] = cells[dptr] + 8'd1;
                            OP_DEC:   cells[dptr] = cells[dptr] - 8'd1;
                            OP_RIGHT: dptr = (dptr + 1 >= MEM_DEPTH) ? 0 : dptr + 1;
                            OP_LEFT:  dptr = (dptr == 0) ? MEM_DEPTH - 1 : dptr - 1;
                            OP_OUT: begin
                                r.out_valid = 1'b1;
                                r.out_byte  = cells[dptr];
                            end
                            OP_IN:    if (iv) cells[dptr] = ib;
                            OP_OPEN:  if (cells[dptr] == 8'd0) next_pc = partner_of[pc_now] + 1;
                            default:  if (cells[dptr] != 8'd0) next_pc = partner_of[pc_now] + 1;
                        endcase
                        pc_now = next_pc;
                    end
                end
                CMD_END: if (depth_now != 0) sticky_err = ST_UNBAL;
                default: ;
            endcase
        end
        if (sticky_err != ST_OK) r.status = sticky_err;
        return r;
    endfunction

    function automatic int idle_pct(input logic sink_side);
        if (work_items < WORK_ITEMS / 3) return sink_side ? 54 : 24;
        if (work_items < 2 * WORK_ITEMS / 3) return sink_side ? 24 : 54;
        return 0;
    endfunction

    function automatic stim_row_t row(input logic [1:0] cmd, input logic [7:0] sym,
                                      input logic iv, input logic [7:0] ib, input logic typed,
                                      input logic ov, input logic [7:0] ob,
                                      input logic [STAT_W-1:0] st);
        stim_row_t s;
        s.cmd            = cmd;
        s.sym            = sym;
        s.in_valid       = iv;
        s.in_byte        = ib;
        s.typed          = typed;
        s.want.out_valid = ov;
        s.want.out_byte  = ob;
        s.want.status    = st;
        return s;
    endfunction

    function automatic logic [7:0] plain_symbol(input int top);
        case ($urandom_range(0, top))
            0:       return SYM_INC;
            1:       return SYM_DEC;
            2:       return SYM_OUT;
            3:       return SYM_IN;
            4:       return SYM_RIGHT;
            default: return SYM_LEFT;
        endcase
    endfunction

    // one command transaction; the model advances when the block takes it
    task automatic issue(input logic [1:0] cmd, input logic [7:0] sym, input logic iv,
                         input logic [7:0] ib, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ib, sym};
        s_tuser  <= {iv, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = step_machine(cmd, sym, iv, ib);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic run_next();
        logic       iv;
        logic [7:0] ib;
        iv = 1'($urandom_range(0, 1));
        ib = 8'($urandom());
        // a ',' right before '[' sets a small trip count so loops end soon
        if (pc_now + 1 < loaded && prog_ops[pc_now] == OP_IN && prog_ops[pc_now + 1] == OP_OPEN)
        begin
            iv = 1'b1;
            ib = 8'($urandom_range(0, 3));
        end
        issue(CMD_RUN, 8'($urandom()), iv, ib, 1'b0, '0);
    endtask

    // balanced code; a loop body only decrements its own cell and nets zero pointer moves
    task automatic build_snippet();
        int units;
        int groups;
        units = $urandom_range(1, 6);
        repeat (units) begin
            if ($urandom_range(0, 2) == 0) begin
                pending_syms.push_back(SYM_IN);
                pending_syms.push_back(SYM_OPEN);
                pending_syms.push_back(SYM_DEC);
                groups = $urandom_range(0, 3);
                repeat (groups) begin
                    pending_syms.push_back(SYM_RIGHT);
                    if ($urandom_range(0, 3) == 0) begin
                        pending_syms.push_back(SYM_IN);
                        pending_syms.push_back(SYM_OPEN);
                        pending_syms.push_back(SYM_DEC);
                        pending_syms.push_back(SYM_RIGHT);
                        pending_syms.push_back(plain_symbol(3));
                        pending_syms.push_back(SYM_LEFT);
                        pending_syms.push_back(SYM_CLOSE);
                    end else begin
                        pending_syms.push_back(plain_symbol(3));
                    end
                    pending_syms.push_back(SYM_LEFT);
                end
                pending_syms.push_back(SYM_CLOSE);
            end else begin
                pending_syms.push_back(plain_symbol(5));
            end
        end
    endtask

    task automatic send_noise();
        logic [7:0] sym;
        t_op        op;
        case ($urandom_range(0, 3))
            0: begin
                do sym = 8'($urandom()); while (decode_char(sym, op));
                issue(CMD_LOAD, sym, 1'($urandom_range(0, 1)), 8'($urandom()), 1'b0, '0);
            end
            1: issue(CMD_SPARE, 8'($urandom()), 1'($urandom_range(0, 1)), 8'($urandom()),
                     1'b0, '0);
            2: issue((depth_now == 0) ? CMD_END : CMD_SPARE, 8'($urandom()),
                     1'($urandom_range(0, 1)), 8'($urandom()), 1'b0, '0);
            default: run_next();
        endcase
    endtask

    always @(negedge i_clk) m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));

    always @(posedge i_clk) begin : result_check
        result_t got;
        result_t want;
        if (o_m_axis_tvalid && m_tready) begin
            got.out_valid = o_m_axis_tuser;
            got.out_byte  = o_m_axis_tdata[7:0];
            got.status    = o_m_axis_tdata[10:8];
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                errors_seen++;
            end else begin
                want = expected_results.pop_front();
                if (got.out_valid !== want.out_valid) begin
                    $error("out_valid mismatch: expected %0d, got %0d",
                           want.out_valid, got.out_valid);
                    errors_seen++;
                end
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte mismatch: expected %0d, got %0d",
                           want.out_byte, got.out_byte);
                    errors_seen++;
                end
                if (got.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                    errors_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   directed_rows [$];
        stim_row_t   step;
        result_t     err_want;
        error_case_t err_case;
        logic [7:0]  sym;
        int          k;
        int          n;
        int          runs;
        int          budget;

        for (k = 0; k < MEM_DEPTH; k++) cells[k] = 8'h00;

        // errors are sticky, so only one kind can be hit per run; a full store would
        // take a whole program's worth of loads, so it is only the fallback below
        err_case = error_case_t'($urandom_range(0, 2));
        if (err_case == ERR_FULL) err_case = ERR_DEEP;
        // the deep nesting tail spends a full stack of loads
        budget = (err_case == ERR_DEEP) ? WORK_ITEMS - STACK_DEPTH : WORK_ITEMS;

        directed_rows.push_back(row(CMD_RUN,   8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, ST_NONE));
        directed_rows.push_back(row(CMD_LOAD,  8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD,  8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_SPARE, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_END,   8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_LEFT,  1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_DEC,   1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_OUT,   1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_RIGHT, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_IN,    1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_IN,    1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_OUT,   1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_OPEN,  1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_DEC,   1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_LOAD, SYM_INC,   1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        // pointer wraps below zero, cell wraps to 255
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'hFF, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b1, 8'h01, 1'b0, 1'b0, 8'h00, ST_OK));
        // end of input keeps the cell
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'hFE, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK));
        directed_rows.push_back(row(CMD_RUN, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, ST_NONE));

        repeat (2) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            step = directed_rows[k];
            issue(step.cmd, step.sym, step.in_valid, step.in_byte, step.typed, step.want);
            work_items++;
        end

        while (work_items < budget) begin
            if (pending_syms.size() == 0) build_snippet();
            n = pending_syms.size();
            // sometimes stop inside a snippet so brackets stay open across runs
            if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) send_noise();
                sym = pending_syms.pop_front();
                issue(CMD_LOAD, sym, 1'($urandom_range(0, 1)), 8'($urandom()), 1'b0, '0);
                work_items++;
            end
            runs = 0;
            while (pc_now < balanced_end && runs < 150) begin
                run_next();
                runs++;
                work_items++;
            end
            repeat ($urandom_range(0, 2)) begin
                run_next();
                work_items++;
            end
        end

        while (pending_syms.size() != 0) begin
            sym = pending_syms.pop_front();
            issue(CMD_LOAD, sym, 1'($urandom_range(0, 1)), 8'($urandom()), 1'b0, '0);
        end
        runs = 0;
        while (pc_now < balanced_end && runs < 400) begin
            run_next();
            runs++;
        end

        if (err_case == ERR_DEEP && loaded + STACK_DEPTH + 1 > PROG_DEPTH) err_case = ERR_FULL;
        err_want = '0;
        case (err_case)
            ERR_CLOSE: begin
                err_want.status = ST_UNBAL;
                issue(CMD_LOAD, SYM_CLOSE, 1'b0, 8'h00, 1'b1, err_want);
            end
            ERR_END: begin
                err_want.status = ST_UNBAL;
                issue(CMD_LOAD, SYM_OPEN, 1'b0, 8'h00, 1'b0, '0);
                issue(CMD_END, 8'h00, 1'b0, 8'h00, 1'b1, err_want);
            end
            ERR_FULL: begin
                err_want.status = ST_FULL;
                while (loaded < PROG_DEPTH) issue(CMD_LOAD, SYM_INC, 1'b0, 8'h00, 1'b0, '0);
                sym = $urandom_range(0, 1) ? SYM_CLOSE : plain_symbol(5);
                issue(CMD_LOAD, sym, 1'b0, 8'h00, 1'b1, err_want);
            end
            default: begin
                err_want.status = ST_DEEP;
                repeat (STACK_DEPTH - depth_now) begin
                    issue(CMD_LOAD, SYM_OPEN, 1'b0, 8'h00, 1'b0, '0);
                end
                issue(CMD_LOAD, SYM_OPEN, 1'b0, 8'h00, 1'b1, err_want);
            end
        endcase
        repeat (4) begin
            issue(2'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom_range(0, 1)),
                  8'($urandom()), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors_seen == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_ctrl.sv
rtl/brainfuck_machine_top.sv
verif/testbench.sv
